// ===== rtl/gaze_deadzone_smoother_assert.svh =====
// Assertion helpers, sampled on clk_i and off while rst_ni is low.
`ifndef GAZE_DEADZONE_SMOOTHER_ASSERT_SVH
`define GAZE_DEADZONE_SMOOTHER_ASSERT_SVH

// Same-cycle implication.
`define GDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gds assertion failed");

// Next-cycle implication.
`define GDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gds assertion failed");

`endif

// ===== rtl/gds_pkg.sv =====
package gds_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned ErrW   = PosW + 1;
  localparam int unsigned FiltW  = 24;
  localparam int unsigned IntegW = 20;
  localparam int unsigned GainW  = 16;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [30:0] FiltMin  = -31'sd8388608;
  localparam logic signed [30:0] FiltMax  = 31'sd8388607;
  localparam logic signed [20:0] IntegMin = -21'sd524288;
  localparam logic signed [20:0] IntegMax = 21'sd524287;

  localparam logic [15:0] DeadZoneRst      = 16'd128;
  localparam logic [16:0] SlowZoneRst      = 17'd640;
  localparam logic [15:0] FastGainRst      = 16'd32768;
  localparam logic [15:0] SlowGainRst      = 16'd2621;
  localparam logic [15:0] IntegDeadZoneRst = 16'd16;
  localparam logic [15:0] IntegGainRst     = 16'd13107;
  localparam logic [31:0] JumpLimitSqRst   = 32'd81920;

  typedef enum logic [CfgIdxW-1:0] {
    RegDeadZone      = 3'd0,
    RegSlowZone      = 3'd1,
    RegFastGain      = 3'd2,
    RegSlowGain      = 3'd3,
    RegIntegDeadZone = 3'd4,
    RegIntegGain     = 3'd5,
    RegJumpLimitSq   = 3'd6
  } gds_reg_e;

  typedef struct packed {
    logic [15:0] dead_zone;
    logic [16:0] slow_zone;
    logic [15:0] fast_gain;
    logic [15:0] slow_gain;
    logic [15:0] integ_dead_zone;
    logic [15:0] integ_gain;
    logic [31:0] jump_limit_sq;
  } gds_cfg_t;

  // Next state of one axis after an accepted sample.
  typedef struct packed {
    logic signed [FiltW-1:0]  filt;
    logic signed [IntegW-1:0] integ;
    logic                     corr;
  } gds_axis_t;

endpackage

// ===== rtl/gds_stream_if.sv =====
interface gds_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] gaze_x;
  logic signed [15:0] gaze_y;

  modport source (output valid, output gaze_x, output gaze_y, input ready);
  modport sink   (input valid, input gaze_x, input gaze_y, output ready);
endinterface

interface gds_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] smooth_x;
  logic signed [15:0] smooth_y;
  logic               rejected;

  modport source (output valid, output smooth_x, output smooth_y, output rejected,
                  input ready);
  modport sink   (input valid, input smooth_x, input smooth_y, input rejected,
                  output ready);
endinterface

// ===== rtl/gds_cfg.sv =====
module gds_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gds_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gds_pkg::CfgW-1:0]      cfg_wdata_i,
  output gds_pkg::gds_cfg_t             cfg_o
);

  gds_pkg::gds_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (gds_pkg::gds_reg_e'(cfg_idx_i))
        gds_pkg::RegDeadZone:      cfg_d.dead_zone       = cfg_wdata_i[15:0];
        gds_pkg::RegSlowZone:      cfg_d.slow_zone       = cfg_wdata_i[16:0];
        gds_pkg::RegFastGain:      cfg_d.fast_gain       = cfg_wdata_i[15:0];
        gds_pkg::RegSlowGain:      cfg_d.slow_gain       = cfg_wdata_i[15:0];
        gds_pkg::RegIntegDeadZone: cfg_d.integ_dead_zone = cfg_wdata_i[15:0];
        gds_pkg::RegIntegGain:     cfg_d.integ_gain      = cfg_wdata_i[15:0];
        gds_pkg::RegJumpLimitSq:   cfg_d.jump_limit_sq   = cfg_wdata_i[31:0];
        default: ; // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_zone       <= gds_pkg::DeadZoneRst;
      cfg_q.slow_zone       <= gds_pkg::SlowZoneRst;
      cfg_q.fast_gain       <= gds_pkg::FastGainRst;
      cfg_q.slow_gain       <= gds_pkg::SlowGainRst;
      cfg_q.integ_dead_zone <= gds_pkg::IntegDeadZoneRst;
      cfg_q.integ_gain      <= gds_pkg::IntegGainRst;
      cfg_q.jump_limit_sq   <= gds_pkg::JumpLimitSqRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/gds_axis.sv =====
module gds_axis (
  input  logic signed [gds_pkg::FiltW-1:0]  filt_i,
  input  logic signed [gds_pkg::IntegW-1:0] integ_i,
  input  logic signed [gds_pkg::ErrW-1:0]   err_i,
  input  logic [gds_pkg::GainW-1:0]         gain_i,
  input  logic [15:0]                       dead_zone_i,
  input  logic [15:0]                       integ_dead_zone_i,
  input  logic [gds_pkg::GainW-1:0]         integ_gain_i,
  output gds_pkg::gds_axis_t                next_o
);

  logic signed [20:0] integ_sum;
  logic signed [19:0] integ_sat;
  logic [16:0]        err_mag;
  logic [19:0]        integ_mag;
  logic               step_on;
  logic               corr;
  logic signed [16:0] gain_s;
  logic signed [16:0] igain_s;
  logic signed [33:0] gain_prod;
  logic signed [36:0] integ_prod;
  logic signed [30:0] step_gain;
  logic signed [30:0] step_int;
  logic signed [30:0] filt_sum;
  logic signed [23:0] filt_sat;

  assign integ_sum = {integ_i[19], integ_i} + {{4{err_i[16]}}, err_i};

  always_comb begin
    priority if (integ_sum > gds_pkg::IntegMax) begin
      integ_sat = gds_pkg::IntegMax[19:0];
    end else if (integ_sum < gds_pkg::IntegMin) begin
      integ_sat = gds_pkg::IntegMin[19:0];
    end else begin
      integ_sat = integ_sum[19:0];
    end
  end

  assign err_mag   = err_i[16] ? 17'(-err_i) : 17'(err_i);
  assign integ_mag = integ_sat[19] ? 20'(-integ_sat) : 20'(integ_sat);
  assign step_on   = err_mag > {1'b0, dead_zone_i};
  assign corr      = integ_mag > {4'b0, integ_dead_zone_i};

  assign gain_s     = {1'b0, gain_i};
  assign igain_s    = {1'b0, integ_gain_i};
  assign gain_prod  = gain_s * err_i;
  assign integ_prod = igain_s * integ_sat;

  // arithmetic >> 8 of the products is a floor
  assign step_gain = step_on ? {{5{gain_prod[33]}}, gain_prod[33:8]} : '0;
  assign step_int  = corr ? {{2{integ_prod[36]}}, integ_prod[36:8]} : '0;
  assign filt_sum  = {{7{filt_i[23]}}, filt_i} + step_gain + step_int;

  always_comb begin
    priority if (filt_sum > gds_pkg::FiltMax) begin
      filt_sat = gds_pkg::FiltMax[23:0];
    end else if (filt_sum < gds_pkg::FiltMin) begin
      filt_sat = gds_pkg::FiltMin[23:0];
    end else begin
      filt_sat = filt_sum[23:0];
    end
  end

  assign next_o.filt  = filt_sat;
  assign next_o.integ = corr ? '0 : integ_sat;
  assign next_o.corr  = corr;

endmodule

// ===== rtl/gaze_deadzone_smoother.sv =====
// Gaze deadzone smoother.
// sample_if (sink) takes one raw gaze sample per item, gaze_x/gaze_y in
// signed pixels*16. result_if (source) gives one item per sample: the
// smoothed position smooth_x/smooth_y and a rejected flag for outliers.
// The user must write registers through cfg_we_i/cfg_idx_i/cfg_wdata_i only
// while idle; the block does not enforce this.
// Throughput: one item per cycle while result_if.ready is high; the filter
// update is a single pass between the sample register and the result
// register, with the six multipliers working side by side.
// Reset: all config registers take their documented defaults and the filter
// state (previous sample, filtered position, integrators) goes to zero.
// Stall: while a result is held and result_if.ready is low, the result
// register holds; the sample register still fills, after which
// sample_if.ready drops until the result is taken.
`include "gaze_deadzone_smoother_assert.svh"

module gaze_deadzone_smoother (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gds_sample_if.sink                  sample_if,
  gds_result_if.source                result_if,
  input  logic                        cfg_we_i,
  input  logic [gds_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gds_pkg::CfgW-1:0]    cfg_wdata_i
);

  gds_pkg::gds_cfg_t cfg;

  gds_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sample register
  logic               s1_valid_q, s1_valid_d;
  logic signed [15:0] s1_x_q, s1_y_q;

  // filter state
  logic signed [15:0] prev_x_q, prev_y_q;
  logic signed [23:0] filt_x_q, filt_y_q, filt_x_d, filt_y_d;
  logic signed [19:0] integ_x_q, integ_y_q, integ_x_d, integ_y_d;

  // result register
  logic               out_valid_q;
  logic signed [15:0] out_x_q, out_y_q;
  logic               out_rej_q;

  logic advance, step_fire, in_fire;

  assign advance   = !out_valid_q || result_if.ready;
  assign step_fire = s1_valid_q && advance;
  assign sample_if.ready = !s1_valid_q || advance;
  assign in_fire   = sample_if.valid && sample_if.ready;

  // outlier test
  logic signed [16:0] dx, dy;
  logic signed [33:0] dx_sq, dy_sq;
  logic [32:0]        jump_sq;
  logic               reject;

  assign dx      = {prev_x_q[15], prev_x_q} - {s1_x_q[15], s1_x_q};
  assign dy      = {prev_y_q[15], prev_y_q} - {s1_y_q[15], s1_y_q};
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign jump_sq = {1'b0, dx_sq[31:0]} + {1'b0, dy_sq[31:0]};
  assign reject  = jump_sq > {1'b0, cfg.jump_limit_sq};

  // error against the held output position, gain picked by the summed error
  logic signed [16:0] ex, ey;
  logic signed [17:0] esum;
  logic [17:0]        esum_mag;
  logic [15:0]        gain;

  assign ex       = {s1_x_q[15], s1_x_q} - {filt_x_q[23], filt_x_q[23:8]};
  assign ey       = {s1_y_q[15], s1_y_q} - {filt_y_q[23], filt_y_q[23:8]};
  assign esum     = {ex[16], ex} + {ey[16], ey};
  assign esum_mag = esum[17] ? 18'(-esum) : 18'(esum);
  assign gain     = (esum_mag > {1'b0, cfg.slow_zone}) ? cfg.fast_gain : cfg.slow_gain;

  gds_pkg::gds_axis_t nx, ny;

  gds_axis u_axis_x (
    .filt_i            (filt_x_q),
    .integ_i           (integ_x_q),
    .err_i             (ex),
    .gain_i            (gain),
    .dead_zone_i       (cfg.dead_zone),
    .integ_dead_zone_i (cfg.integ_dead_zone),
    .integ_gain_i      (cfg.integ_gain),
    .next_o            (nx)
  );

  gds_axis u_axis_y (
    .filt_i            (filt_y_q),
    .integ_i           (integ_y_q),
    .err_i             (ey),
    .gain_i            (gain),
    .dead_zone_i       (cfg.dead_zone),
    .integ_dead_zone_i (cfg.integ_dead_zone),
    .integ_gain_i      (cfg.integ_gain),
    .next_o            (ny)
  );

  assign filt_x_d  = reject ? filt_x_q  : nx.filt;
  assign filt_y_d  = reject ? filt_y_q  : ny.filt;
  assign integ_x_d = reject ? integ_x_q : nx.integ;
  assign integ_y_d = reject ? integ_y_q : ny.integ;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      filt_x_q    <= '0;
      filt_y_q    <= '0;
      integ_x_q   <= '0;
      integ_y_q   <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (step_fire) begin
        prev_x_q  <= s1_x_q;
        prev_y_q  <= s1_y_q;
        filt_x_q  <= filt_x_d;
        filt_y_q  <= filt_y_d;
        integ_x_q <= integ_x_d;
        integ_y_q <= integ_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q <= sample_if.gaze_x;
      s1_y_q <= sample_if.gaze_y;
    end
    if (step_fire) begin
      out_x_q   <= filt_x_d[23:8];
      out_y_q   <= filt_y_d[23:8];
      out_rej_q <= reject;
    end
  end

  assign result_if.valid    = out_valid_q;
  assign result_if.smooth_x = out_x_q;
  assign result_if.smooth_y = out_y_q;
  assign result_if.rejected = out_rej_q;

  `GDS_ASSERT_IMP(a_ready_when_empty, !out_valid_q, sample_if.ready)
  `GDS_ASSERT_NXT(a_reject_holds_state, step_fire && reject,
                  $stable(filt_x_q) && $stable(filt_y_q) && $stable(integ_x_q))
  `GDS_ASSERT_NXT(a_corr_clears_integ, step_fire && !reject && nx.corr, integ_x_q == '0)
  `GDS_ASSERT_IMP(a_result_has_source, $rose(out_valid_q), $past(s1_valid_q))

endmodule
